// ----- hw/rtl/proximity_speed_governor_core_defines.svh -----
// ----------------------------------------------------------------------------
// proximity speed governor assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_SPEED_GOVERNOR_CORE_DEFINES_SVH
`define PROXIMITY_SPEED_GOVERNOR_CORE_DEFINES_SVH

// same-cycle implication
`define PSG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/psg_pkg.sv -----
// ----------------------------------------------------------------------------
// psg_pkg
// types, register codes and helpers shared by the speed governor modules
// ----------------------------------------------------------------------------
package psg_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_SPEED_SET   = 3'd0,
    REG_ROTATE_SET  = 3'd1,
    REG_SLOW_THR    = 3'd2,
    REG_STOP_THR    = 3'd3,
    REG_RANGE_CLAMP = 3'd4,
    REG_UPDATE_RATE = 3'd5
  } psg_reg_e;

  // reset values of the registers
  localparam logic [15:0] SLOW_THR_RST    = 16'd2458;
  localparam logic [15:0] STOP_THR_RST    = 16'd614;
  localparam logic [15:0] RANGE_CLAMP_RST = 16'd4096;
  localparam logic [9:0]  UPDATE_RATE_RST = 10'd20;

  // floor(x / 3) for x below 2^18 as (x * DIV3_MUL) >> DIV3_SHIFT
  localparam int unsigned DIV3_SHIFT = 20;
  localparam logic [19:0] DIV3_MUL   = 20'd349526;

  // configuration as seen by the datapath
  typedef struct packed {
    logic signed [31:0] speed_set;
    logic signed [15:0] rotate_set;
    logic [15:0]        slow_thr;
    logic [15:0]        stop_thr;
    logic [15:0]        range_clamp;
    logic [9:0]         update_rate;
  } psg_cfg_t;

  // one tick after the front end: clamped ranges and position change
  typedef struct packed {
    logic [15:0]        rl;
    logic [15:0]        rr;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } psg_item_t;

  // queue handshake between front, queue and back
  typedef struct packed {
    logic push;
    logic pop;
  } psg_qreq_t;

  typedef struct packed {
    logic full;
    logic valid;
  } psg_qsts_t;

  // saturate a 33-bit signed value to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/psg_front.sv -----
// ----------------------------------------------------------------------------
// psg_front
// takes ticks, clamps the ranges and forms the saturated position change
// ----------------------------------------------------------------------------
module psg_front import psg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [95:0] data_i,       // range_left, range_right, pos_x, pos_y
  input  logic [15:0] range_clamp_i,
  input  psg_qsts_t   qsts_i,
  output logic        push_o,
  output psg_item_t   item_o
);

  logic [15:0]        rl_raw, rr_raw;
  logic signed [31:0] px, py;
  logic signed [31:0] prev_x_q, prev_y_q;
  logic signed [32:0] diff_x, diff_y;

  assign rl_raw = data_i[15:0];
  assign rr_raw = data_i[31:16];
  assign px     = data_i[63:32];
  assign py     = data_i[95:64];

  // accept whenever the queue has room
  assign ready_o = !qsts_i.full;
  assign push_o  = valid_i && !qsts_i.full;

  // position change against the last accepted position
  assign diff_x = {px[31], px} - {prev_x_q[31], prev_x_q};
  assign diff_y = {py[31], py} - {prev_y_q[31], prev_y_q};

  always_comb begin
    item_o.rl = (rl_raw > range_clamp_i) ? range_clamp_i : rl_raw;
    item_o.rr = (rr_raw > range_clamp_i) ? range_clamp_i : rr_raw;
    item_o.dx = sat33(diff_x);
    item_o.dy = sat33(diff_y);
  end

  // last position follows every accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (push_o) begin
      prev_x_q <= px;
      prev_y_q <= py;
    end
  end

endmodule

// ----- hw/rtl/psg_fifo.sv -----
// ----------------------------------------------------------------------------
// psg_fifo
// short queue of prepared ticks between front end and back end
// ----------------------------------------------------------------------------
module psg_fifo import psg_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  psg_qreq_t req_i,
  input  psg_item_t item_i,
  output psg_qsts_t sts_o,
  output psg_item_t item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  psg_item_t     mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign sts_o.full  = (count_q == CW'(DEPTH));
  assign sts_o.valid = (count_q != '0);
  assign do_push     = req_i.push && !sts_o.full;
  assign do_pop      = req_i.pop && sts_o.valid;
  assign item_o      = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/psg_back.sv -----
// ----------------------------------------------------------------------------
// psg_back
// sequenced datapath: squares, bit-pair square root, averages, decision
// ----------------------------------------------------------------------------
`include "proximity_speed_governor_core_defines.svh"

module psg_back import psg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psg_cfg_t           cfg_i,
  input  psg_qsts_t          qsts_i,
  input  psg_item_t          item_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] speed_o,
  output logic signed [15:0] rotate_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_ROOT,
    ST_GSPD,
    ST_AVG,
    ST_CLOSE,
    ST_DECIDE
  } state_e;

  state_e             state_q;
  psg_item_t          item_q;

  // history
  logic [15:0]        lh1_q, lh2_q, rh1_q, rh2_q, prev_lavg_q;
  logic signed [31:0] last_speed_q;
  logic signed [15:0] last_rot_q;

  // work registers
  logic [63:0]        prod_q, acc_q, rad_q;
  logic [35:0]        rem_q;
  logic [31:0]        root_q;
  logic [4:0]         cnt_q;
  logic signed [31:0] gspd_q, closing_q;
  logic [15:0]        lavg_q, ravg_q;

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_speed_q;
  logic signed [15:0] out_rot_q;

  // shared multiplier and helpers
  logic [31:0]        ux, uy, mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [35:0]        rem_sh, trial;
  logic [17:0]        lsum, rsum;
  logic [37:0]        lmul, rmul;
  logic signed [16:0] adiff;
  logic signed [10:0] srate;
  logic signed [27:0] cprod;
  logic signed [31:0] slow_spd, spd, cap_spd;
  logic signed [15:0] rot;
  logic               l_slow, r_slow, out_free;

  assign pop_o    = (state_q == ST_IDLE) && qsts_i.valid;
  assign out_free = !out_valid_q || ready_i;
  assign valid_o  = out_valid_q;
  assign speed_o  = out_speed_q;
  assign rotate_o = out_rot_q;

  // magnitudes of the position change
  assign ux = item_q.dx[31] ? (~item_q.dx + 32'd1) : item_q.dx;
  assign uy = item_q.dy[31] ? (~item_q.dy + 32'd1) : item_q.dy;

  // operand selection for the one 32x32 multiplier
  always_comb begin
    case (state_q)
      ST_SQX:  begin mul_a = ux;     mul_b = ux;                   end
      ST_SQY:  begin mul_a = uy;     mul_b = uy;                   end
      ST_GSPD: begin mul_a = root_q; mul_b = 32'(cfg_i.update_rate); end
      default: begin mul_a = '0;     mul_b = '0;                   end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one root bit per cycle
  assign rem_sh = {rem_q[33:0], rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  // three-tap averages by reciprocal multiply
  assign lsum = 18'(item_q.rl) + 18'(lh1_q) + 18'(lh2_q);
  assign rsum = 18'(item_q.rr) + 18'(rh1_q) + 18'(rh2_q);
  assign lmul = lsum * DIV3_MUL;
  assign rmul = rsum * DIV3_MUL;

  // closing rate, Q4.12 difference scaled to Q15.16
  assign adiff = $signed({1'b0, prev_lavg_q}) - $signed({1'b0, lavg_q});
  assign srate = $signed({1'b0, cfg_i.update_rate});
  assign cprod = adiff * srate;

  // zone decision and speed cap
  assign slow_spd = sat33({gspd_q[31], gspd_q} - {closing_q[31], closing_q});
  assign l_slow   = (lavg_q < cfg_i.slow_thr) && (lavg_q > cfg_i.stop_thr);
  assign r_slow   = (ravg_q < cfg_i.slow_thr) && (ravg_q > cfg_i.stop_thr);

  always_comb begin
    if ((l_slow || r_slow) && (last_speed_q > 32'sd0)) begin
      spd = slow_spd;
      rot = last_rot_q;
    end else if ((lavg_q < cfg_i.stop_thr) || (ravg_q < cfg_i.stop_thr)) begin
      spd = '0;
      rot = '0;
    end else begin
      spd = cfg_i.speed_set;
      rot = cfg_i.rotate_set;
    end
    cap_spd = (spd > cfg_i.speed_set) ? cfg_i.speed_set : spd;
    if ((cfg_i.speed_set > 32'sd0) && (cap_spd < 32'sd0)) begin
      cap_spd = '0;
    end
  end

  // sequencer, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lh1_q        <= '0;
      lh2_q        <= '0;
      rh1_q        <= '0;
      rh2_q        <= '0;
      prev_lavg_q  <= '0;
      last_speed_q <= '0;
      last_rot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_rot_q    <= '0;
      item_q       <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      rad_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      cnt_q        <= '0;
      gspd_q       <= '0;
      closing_q    <= '0;
      lavg_q       <= '0;
      ravg_q       <= '0;
    end else begin
      // output taken; the decision step refills it on its own
      if (out_valid_q && ready_i && (state_q != ST_DECIDE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (qsts_i.valid) begin
            item_q  <= item_i;
            state_q <= ST_SQX;
          end
        end
        ST_SQX: begin
          prod_q  <= mul_p;
          state_q <= ST_SQY;
        end
        ST_SQY: begin
          acc_q   <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          rad_q   <= acc_q + prod_q;
          rem_q   <= '0;
          root_q  <= '0;
          cnt_q   <= 5'd31;
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[30:0], 1'b0};
          end
          rad_q <= {rad_q[61:0], 2'b00};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == '0) begin
            state_q <= ST_GSPD;
          end
        end
        ST_GSPD: begin
          prod_q  <= mul_p;
          state_q <= ST_AVG;
        end
        ST_AVG: begin
          gspd_q  <= (prod_q > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(prod_q[31:0]);
          lavg_q  <= lmul[DIV3_SHIFT +: 16];
          ravg_q  <= rmul[DIV3_SHIFT +: 16];
          state_q <= ST_CLOSE;
        end
        ST_CLOSE: begin
          closing_q <= {cprod, 4'b0000};
          state_q   <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_speed_q  <= cap_spd;
            out_rot_q    <= rot;
            lh2_q        <= lh1_q;
            lh1_q        <= item_q.rl;
            rh2_q        <= rh1_q;
            rh1_q        <= item_q.rr;
            prev_lavg_q  <= lavg_q;
            last_speed_q <= cap_spd;
            last_rot_q   <= rot;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // a result appears only on leaving the decision step
  `PSG_ASSERT_IMPL(a_out_decide, $rose(out_valid_q), $past(state_q) == ST_DECIDE, "stray result")
  // the root loop runs until its count is spent
  `PSG_ASSERT_NEXT(a_root_run, state_q == ST_ROOT && cnt_q != '0, state_q == ST_ROOT, "early exit")
  // a popped tick starts the square step
  `PSG_ASSERT_NEXT(a_pop_starts, pop_o, state_q == ST_SQX, "pop did not start work")

endmodule

// ----- hw/rtl/proximity_speed_governor_core.sv -----
// ----------------------------------------------------------------------------
// proximity_speed_governor_core
// speed and rotation governor driven by front range readings and position
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | range_left, range_right, pos_x, pos_y
//  m_axis    | out       | speed_cmd, rotate_cmd
//  apb       | in        | six registers at byte address 4*i
//
// a tick passes through the back end as a queue pop, two squares on the
// shared 32x32 multiplier, a sum, 32 steps of the bit-pair square root,
// the ground speed multiply, averages, closing rate and the decision.
// the front end and a two-entry queue take new ticks while the back end works;
// a result waiting in the output register holds only the decision step.
// reset clears registers, history and queue at once; no clearing pass.
// ----------------------------------------------------------------------------
module proximity_speed_governor_core import psg_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // ticks in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // range_left, range_right, pos_x, pos_y
  // commands out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // speed_cmd, rotate_cmd
);

  psg_cfg_t           cfg_q;
  psg_reg_e           reg_idx;
  psg_qreq_t          qreq;
  psg_qsts_t          qsts;
  psg_item_t          front_item, queue_item;
  logic               cfg_wr;
  logic               q_push, q_pop;
  logic signed [31:0] speed_cmd;
  logic signed [15:0] rotate_cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = psg_reg_e'(paddr[4:2]);

  // queue request from both sides
  assign qreq = '{push: q_push, pop: q_pop};

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_set   <= '0;
      cfg_q.rotate_set  <= '0;
      cfg_q.slow_thr    <= SLOW_THR_RST;
      cfg_q.stop_thr    <= STOP_THR_RST;
      cfg_q.range_clamp <= RANGE_CLAMP_RST;
      cfg_q.update_rate <= UPDATE_RATE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SPEED_SET:   cfg_q.speed_set   <= pwdata;
        REG_ROTATE_SET:  cfg_q.rotate_set  <= pwdata[15:0];
        REG_SLOW_THR:    cfg_q.slow_thr    <= pwdata[15:0];
        REG_STOP_THR:    cfg_q.stop_thr    <= pwdata[15:0];
        REG_RANGE_CLAMP: cfg_q.range_clamp <= pwdata[15:0];
        REG_UPDATE_RATE: cfg_q.update_rate <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_SPEED_SET:   prdata = cfg_q.speed_set;
      REG_ROTATE_SET:  prdata = {16'd0, cfg_q.rotate_set};
      REG_SLOW_THR:    prdata = {16'd0, cfg_q.slow_thr};
      REG_STOP_THR:    prdata = {16'd0, cfg_q.stop_thr};
      REG_RANGE_CLAMP: prdata = {16'd0, cfg_q.range_clamp};
      REG_UPDATE_RATE: prdata = {22'd0, cfg_q.update_rate};
      default:         prdata = '0;
    endcase
  end

  // front end
  psg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .data_i        (s_axis_tdata),
    .range_clamp_i (cfg_q.range_clamp),
    .qsts_i        (qsts),
    .push_o        (q_push),
    .item_o        (front_item)
  );

  // tick queue
  psg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .item_i (front_item),
    .sts_o  (qsts),
    .item_o (queue_item)
  );

  // back end
  psg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .qsts_i   (qsts),
    .item_i   (queue_item),
    .pop_o    (q_pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .speed_o  (speed_cmd),
    .rotate_o (rotate_cmd)
  );

  assign m_axis_tdata = {rotate_cmd, speed_cmd};

endmodule

// ----- tb/tb_proximity_speed_governor_core.sv -----
// ----------------------------------------------------------------------------
// tb_proximity_speed_governor_core
// self-checking bench: ticks go in on the stream input and each command that
// comes out is compared with a behavioral predictor of the governor. random
// gaps on both sides, a long output hold-off and several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_proximity_speed_governor_core;
  import psg_pkg::*;

  // register slots past the map, writes there must change nothing
  localparam logic [2:0] UNMAPPED_REG_A = 3'd6;
  localparam logic [2:0] UNMAPPED_REG_B = 3'd7;

  localparam longint SPEED_MAX = 64'sd2147483647;
  localparam longint SPEED_MIN = -64'sd2147483648;

  localparam int unsigned HOLD_OFF_CYCLES    = 600;
  localparam int unsigned RANDOM_PHASE_TICKS = 250;
  localparam int unsigned PRESSURE_TICKS     = 40;

  // one control tick request and one command
  typedef struct {
    logic [15:0] range_left;
    logic [15:0] range_right;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } tick_t;

  typedef struct {
    logic [31:0] speed;
    logic [15:0] rotate;
  } command_t;

  // governor predictor and store of expected commands
  class governor_scoreboard;
    psg_cfg_t    cfg;
    logic [15:0] left_h1, left_h2, right_h1, right_h2, last_left_avg;
    logic [31:0] last_pos_x, last_pos_y, last_speed;
    logic [15:0] last_rotate;
    command_t    pending[$];
    int unsigned n_errors, n_ticks, n_slow, n_stop, n_clear;

    function new();
      cfg.speed_set   = '0;
      cfg.rotate_set  = '0;
      cfg.slow_thr    = SLOW_THR_RST;
      cfg.stop_thr    = STOP_THR_RST;
      cfg.range_clamp = RANGE_CLAMP_RST;
      cfg.update_rate = UPDATE_RATE_RST;
      left_h1 = '0;
      left_h2 = '0;
      right_h1 = '0;
      right_h2 = '0;
      last_left_avg = '0;
      last_pos_x = '0;
      last_pos_y = '0;
      last_speed = '0;
      last_rotate = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_SPEED_SET:   cfg.speed_set   = value;
        REG_ROTATE_SET:  cfg.rotate_set  = value[15:0];
        REG_SLOW_THR:    cfg.slow_thr    = value[15:0];
        REG_STOP_THR:    cfg.stop_thr    = value[15:0];
        REG_RANGE_CLAMP: cfg.range_clamp = value[15:0];
        REG_UPDATE_RATE: cfg.update_rate = value[9:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > SPEED_MAX) return SPEED_MAX;
      if (v < SPEED_MIN) return SPEED_MIN;
      return v;
    endfunction

    function logic [15:0] clamp_range(logic [15:0] r);
      return (r > cfg.range_clamp) ? cfg.range_clamp : r;
    endfunction

    // floor square root, two bits per step
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root, probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function void note_tick(tick_t t);
      logic [15:0]     rl, rr, lavg, ravg, rot;
      longint          rate, dx, dy, closing, gspd, spd, cap;
      longint unsigned ux, uy, mag, gsu;
      bit              near_l, near_r;
      command_t        exp_cmd;
      rl = clamp_range(t.range_left);
      rr = clamp_range(t.range_right);
      rate = longint'(cfg.update_rate);

      // ground speed from position change
      dx = clip32(longint'($signed(t.pos_x)) - longint'($signed(last_pos_x)));
      dy = clip32(longint'($signed(t.pos_y)) - longint'($signed(last_pos_y)));
      ux = (dx < 0) ? -dx : dx;
      uy = (dy < 0) ? -dy : dy;
      mag = root_floor(ux * ux + uy * uy);
      gsu = mag * rate;
      gspd = (gsu > 64'd2147483647) ? SPEED_MAX : longint'(gsu);

      // 3-tap averages and closing rate in Q15.16
      lavg = 16'((32'(rl) + 32'(left_h1) + 32'(left_h2)) / 32'd3);
      ravg = 16'((32'(rr) + 32'(right_h1) + 32'(right_h2)) / 32'd3);
      closing = clip32((longint'(last_left_avg) - longint'(lavg)) * rate * 16);

      // zone decision, then the cap
      near_l = (lavg < cfg.slow_thr) && (lavg > cfg.stop_thr);
      near_r = (ravg < cfg.slow_thr) && (ravg > cfg.stop_thr);
      cap = longint'($signed(cfg.speed_set));
      rot = last_rotate;
      if ((near_l || near_r) && $signed(last_speed) > 0) begin
        spd = clip32(gspd - closing);
        n_slow++;
      end else if (lavg < cfg.stop_thr || ravg < cfg.stop_thr) begin
        spd = 0;
        rot = '0;
        n_stop++;
      end else begin
        spd = cap;
        rot = cfg.rotate_set;
        n_clear++;
      end
      if (spd > cap) spd = cap;
      if (cap > 0 && spd < 0) spd = 0;

      // history
      left_h2 = left_h1;
      left_h1 = rl;
      right_h2 = right_h1;
      right_h1 = rr;
      last_left_avg = lavg;
      last_pos_x = t.pos_x;
      last_pos_y = t.pos_y;
      last_speed = spd[31:0];
      last_rotate = rot;

      exp_cmd.speed = spd[31:0];
      exp_cmd.rotate = rot;
      pending.push_back(exp_cmd);
      n_ticks++;
    endfunction

    function void check_command(command_t got);
      command_t want;
      if (pending.size() == 0) begin
        $error("command with no tick waiting: speed_cmd %0d rotate_cmd %0d",
               $signed(got.speed), $signed(got.rotate));
        n_errors++;
        return;
      end
      want = pending.pop_front();
      if (got.speed !== want.speed) begin
        $error("speed_cmd: expected %0d, got %0d", $signed(want.speed), $signed(got.speed));
        n_errors++;
      end
      if (got.rotate !== want.rotate) begin
        $error("rotate_cmd: expected %0d, got %0d", $signed(want.rotate),
               $signed(got.rotate));
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // range_left, range_right, pos_x, pos_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // speed_cmd, rotate_cmd

  governor_scoreboard sb = new();

  bit          sender_steady;
  bit          receiver_steady;
  bit          hold_off_request;
  int unsigned n_commands;
  int unsigned n_settings;
  int unsigned n_input_stalls;

  proximity_speed_governor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("** proximity_speed_governor_core: FAILED **");
    $finish;
  end

  // input back-pressure seen by the sender
  always @(posedge clk_i) begin
    if (s_axis_tvalid && !s_axis_tready) n_input_stalls++;
  end

  function automatic tick_t mk_tick(logic [15:0] rl, logic [15:0] rr,
                                    logic [31:0] px, logic [31:0] py);
    tick_t t;
    t.range_left = rl;
    t.range_right = rr;
    t.pos_x = px;
    t.pos_y = py;
    return t;
  endfunction

  // next reading: mostly a small step from the last one, sometimes a new zone
  function automatic logic [15:0] next_range(logic [15:0] prev, psg_cfg_t c);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: return prev + 16'($urandom_range(0, 64)) - 16'd32;
      5, 6:          return 16'($urandom_range(32'(c.stop_thr), 32'(c.slow_thr)));
      7:             return 16'($urandom_range(0, 32'(c.stop_thr)));
      8:             return 16'($urandom_range(32'(c.slow_thr), 65535));
      default:       return 16'($urandom);
    endcase
  endfunction

  // one register write: setup then access
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
  endtask

  // new settings only once every command has drained
  task automatic configure(psg_cfg_t c);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    apb_write(REG_SPEED_SET, c.speed_set);
    apb_write(REG_ROTATE_SET, {{16{c.rotate_set[15]}}, c.rotate_set});
    apb_write(REG_SLOW_THR, 32'(c.slow_thr));
    apb_write(REG_STOP_THR, 32'(c.stop_thr));
    apb_write(REG_RANGE_CLAMP, 32'(c.range_clamp));
    apb_write(REG_UPDATE_RATE, 32'(c.update_rate));
    n_settings++;
  endtask

  // offer one tick request, called at a falling edge
  task automatic send_tick(tick_t t);
    int unsigned gap;
    gap = sender_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {t.pos_y, t.pos_x, t.range_right, t.range_left};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(t);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // command sink with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    command_t    got;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (n_commands % 50 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      stall = receiver_steady ? 0 : $urandom_range(0, 19);
      if (hold_off_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.speed = m_axis_tdata[31:0];
      got.rotate = m_axis_tdata[47:32];
      sb.check_command(got);
      n_commands++;
      @(negedge clk_i);
    end
  end

  // stimulus
  initial begin
    psg_cfg_t    c;
    int unsigned ph, i;
    logic [31:0] walk_x, walk_y;
    logic [15:0] walk_l, walk_r;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    sender_steady = 1'b0;
    hold_off_request = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: first tick sees its own position as the change
    send_tick(mk_tick(16'd4096, 16'd4096, 32'h7fff_ffff, 32'h8000_0000));
    send_tick(mk_tick(16'd0, 16'hffff, 32'h0000_0000, 32'h0000_0000));
    send_tick(mk_tick(16'hffff, 16'hffff, 32'h8000_0000, 32'h7fff_ffff));

    // positive cruise so the slow zone can engage
    c = sb.cfg;
    c.speed_set = 32'h0002_0000;
    c.rotate_set = 16'h0800;
    configure(c);
    for (i = 0; i < 3; i++) send_tick(mk_tick(16'd4096, 16'd4096, 32'(i * 32'h1000), '0));
    for (i = 0; i < 4; i++) begin
      send_tick(mk_tick(16'd1638, 16'd4096, 32'h3000 + 32'(i * 32'h2000), 32'(i * 32'h800)));
    end
    // averages landing exactly on slow and stop thresholds
    for (i = 0; i < 3; i++) send_tick(mk_tick(16'd2458, 16'd4096, 32'h1_0000, '0));
    for (i = 0; i < 3; i++) send_tick(mk_tick(16'd614, 16'd614, 32'h1_0000, '0));
    for (i = 0; i < 2; i++) send_tick(mk_tick(16'd0, 16'd0, 32'h1_0000, '0));

    // zero update rate, extreme set values, writes past the register map
    c = sb.cfg;
    c.speed_set = 32'h7fff_ffff;
    c.rotate_set = 16'h8000;
    c.update_rate = '0;
    configure(c);
    apb_write(UNMAPPED_REG_A, 32'hffff_ffff);
    apb_write(UNMAPPED_REG_B, 32'h0000_0001);
    send_tick(mk_tick(16'd4096, 16'd4096, 32'h0, 32'h0));
    for (i = 0; i < 3; i++) send_tick(mk_tick(16'd1638, 16'd1638, 32'(i * 32'h4000), '0));

    // random phases with fresh settings each
    walk_x = '0;
    walk_y = '0;
    walk_l = 16'd4096;
    walk_r = 16'd4096;
    for (ph = 0; ph < 6; ph++) begin
      c = sb.cfg;
      case (ph)
        0: begin
          c.speed_set = 32'h7fff_ffff;
          c.rotate_set = 16'h7fff;
          c.slow_thr = 16'hffff;
          c.stop_thr = 16'h0000;
          c.range_clamp = 16'hffff;
          c.update_rate = 10'h3ff;
        end
        1: begin
          c.speed_set = 32'h8000_0000;
          c.rotate_set = 16'h8000;
          c.slow_thr = 16'h0000;
          c.stop_thr = 16'hffff;
          c.range_clamp = 16'h0000;
          c.update_rate = 10'd1;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       c.speed_set = $urandom;
            1:       c.speed_set = -32'($urandom_range(0, 32'h0002_0000));
            default: c.speed_set = 32'($urandom_range(0, 32'h0003_0000));
          endcase
          c.rotate_set = 16'($urandom);
          c.stop_thr = 16'($urandom_range(0, 2000));
          c.slow_thr = c.stop_thr + 16'($urandom_range(1, 4000));
          c.range_clamp = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2048))
                                                      : 16'($urandom_range(2048, 65535));
          case ($urandom_range(0, 9))
            0:       c.update_rate = '0;
            1:       c.update_rate = 10'h3ff;
            default: c.update_rate = 10'($urandom_range(1, 1000));
          endcase
        end
      endcase
      configure(c);
      for (i = 0; i < RANDOM_PHASE_TICKS; i++) begin
        if (i % 50 == 0) sender_steady = ($urandom_range(0, 3) == 0);
        walk_l = next_range(walk_l, c);
        walk_r = next_range(walk_r, c);
        if ($urandom_range(0, 9) == 0) walk_x = $urandom;
        else walk_x = walk_x + 32'($urandom_range(0, 32'h8000)) - 32'h4000;
        if ($urandom_range(0, 9) == 0) walk_y = $urandom;
        else walk_y = walk_y + 32'($urandom_range(0, 32'h8000)) - 32'h4000;
        send_tick(mk_tick(walk_l, walk_r, walk_x, walk_y));
      end
      // sink holds off while ticks keep coming back to back
      if (ph == 2) begin
        hold_off_request = 1'b1;
        sender_steady = 1'b1;
        for (i = 0; i < PRESSURE_TICKS; i++) begin
          walk_l = next_range(walk_l, c);
          walk_r = next_range(walk_r, c);
          walk_x = walk_x + 32'($urandom_range(0, 32'h8000)) - 32'h4000;
          send_tick(mk_tick(walk_l, walk_r, walk_x, walk_y));
        end
      end
    end
    s_axis_tvalid = 1'b0;

    // drain
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);

    $display("run: %0d ticks, %0d commands, %0d register settings, %0d input stall cycles",
             sb.n_ticks, n_commands, n_settings, n_input_stalls);
    $display("decisions: %0d slow zone, %0d stop zone, %0d clear zone",
             sb.n_slow, sb.n_stop, sb.n_clear);
    if (sb.n_errors == 0) begin
      $display("** proximity_speed_governor_core: PASSED **");
    end else begin
      $display("** proximity_speed_governor_core: FAILED **");
    end
    $finish;
  end

endmodule
